FILE: hdl/modexp_pkg.sv
// shared types and constants of the modular exponentiation block
package modexp_pkg;

   localparam int FIELD_W = 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_DOUBLE,
      ST_ADD
   } state_type;

   typedef enum logic {
      PH_SQUARE,
      PH_MULT
   } phase_type;

endpackage

FILE: hdl/modexp_addmod.sv
// shared modular adder: (x + y + cin) mod m for x, y below m
module modexp_addmod #(
   parameter int WIDTH = 32
) (
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] y,
   input  logic             cin,
   input  logic [WIDTH-1:0] m,
   output logic [WIDTH-1:0] r
);

   logic [WIDTH:0] sum;
   logic [WIDTH:0] diff;

   // sum stays below twice the modulus, so one subtract is enough
   assign sum  = {1'b0, x} + {1'b0, y} + {{WIDTH{1'b0}}, cin};
   assign diff = sum - {1'b0, m};
   assign r    = (sum >= {1'b0, m}) ? diff[WIDTH-1:0] : sum[WIDTH-1:0];

endmodule

FILE: hdl/modular_exponentiation.sv
// from the accepted word to the result strobe: the sequencer first reduces the base, then per
// exponent bit does a square and, for a one bit, a multiply, each a double-and-add pass over
// the multiplier bits on the single shared modular adder
// a zero modulus gives its result in the cycle after the word is accepted
// one word at a time: busy stays high until the result strobe; results cannot be stalled
// synchronous reset returns the sequencer to idle with no result pending
module modular_exponentiation #(
   parameter int WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [modexp_pkg::FIELD_W-1:0]     req_base,
   input  logic [modexp_pkg::FIELD_W-1:0]     req_exponent,
   input  logic [modexp_pkg::FIELD_W-1:0]     req_modulus,
   output logic                               rsp_strobe,
   output logic [modexp_pkg::FIELD_W-1:0]     rsp_residue,
   output logic                               rsp_zero_modulus
);
   import modexp_pkg::*;

   localparam int CNT_W = $clog2(WIDTH);
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WIDTH - 1);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic [WIDTH-1:0] mod_ff, mod_in;
   logic [WIDTH-1:0] base_ff, base_in;
   logic [WIDTH-1:0] exp_ff, exp_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] prod_ff, prod_in;
   logic [WIDTH-1:0] mcand_ff, mcand_in;
   logic [WIDTH-1:0] mplier_ff, mplier_in;
   logic [CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0] exp_cnt_ff, exp_cnt_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [FIELD_W-1:0] rsp_residue_ff, rsp_residue_in;
   logic               rsp_zero_ff, rsp_zero_in;

   logic [WIDTH-1:0] base_w, exp_w, mod_w;
   logic [WIDTH-1:0] unit_x, unit_y, unit_r;
   logic             unit_cin;
   logic [WIDTH-1:0] one_mod;
   logic             bit_last, exp_last, step_done, mul_done, need_mult, finish;

   assign base_w = WIDTH'(req_base);
   assign exp_w  = WIDTH'(req_exponent);
   assign mod_w  = WIDTH'(req_modulus);

   assign one_mod   = (mod_ff == WIDTH'(1)) ? '0 : WIDTH'(1);
   assign bit_last  = (bit_cnt_ff == '0);
   assign exp_last  = (exp_cnt_ff == '0);
   assign step_done = ((state_ff == ST_DOUBLE) && !mplier_ff[WIDTH-1]) || (state_ff == ST_ADD);
   assign mul_done  = step_done && bit_last;
   assign need_mult = (phase_ff == PH_SQUARE) && exp_ff[WIDTH-1];
   assign finish    = mul_done && !need_mult && exp_last;

   modexp_addmod #(.WIDTH(WIDTH)) u_addmod (
      .x   (unit_x),
      .y   (unit_y),
      .cin (unit_cin),
      .m   (mod_ff),
      .r   (unit_r)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && (mod_w != '0)) state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (bit_last) state_in = ST_DOUBLE;
         end
         ST_DOUBLE: begin
            if (mplier_ff[WIDTH-1]) state_in = ST_ADD;
            else if (finish) state_in = ST_IDLE;
         end
         ST_ADD: begin
            if (finish) state_in = ST_IDLE;
            else state_in = ST_DOUBLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // shared unit operands and datapath updates
   always_comb begin
      unit_x         = '0;
      unit_y         = '0;
      unit_cin       = 1'b0;
      phase_in       = phase_ff;
      mod_in         = mod_ff;
      base_in        = base_ff;
      exp_in         = exp_ff;
      acc_in         = acc_ff;
      prod_in        = prod_ff;
      mcand_in       = mcand_ff;
      mplier_in      = mplier_ff;
      bit_cnt_in     = bit_cnt_ff;
      exp_cnt_in     = exp_cnt_ff;
      rsp_strobe_in  = 1'b0;
      rsp_residue_in = rsp_residue_ff;
      rsp_zero_in    = rsp_zero_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (mod_w == '0) begin
                  rsp_strobe_in  = 1'b1;
                  rsp_residue_in = '0;
                  rsp_zero_in    = 1'b1;
               end else begin
                  mod_in     = mod_w;
                  base_in    = base_w;
                  exp_in     = exp_w;
                  acc_in     = '0;
                  bit_cnt_in = LAST_BIT;
               end
            end
         end
         ST_REDUCE: begin
            // base mod m, one base bit per cycle
            unit_x     = acc_ff;
            unit_y     = acc_ff;
            unit_cin   = base_ff[WIDTH-1];
            acc_in     = unit_r;
            base_in    = base_ff << 1;
            bit_cnt_in = bit_cnt_ff - CNT_W'(1);
            if (bit_last) begin
               base_in    = unit_r;
               acc_in     = one_mod;
               mcand_in   = one_mod;
               mplier_in  = one_mod;
               prod_in    = '0;
               bit_cnt_in = LAST_BIT;
               exp_cnt_in = LAST_BIT;
               phase_in   = PH_SQUARE;
            end
         end
         ST_DOUBLE, ST_ADD: begin
            if (state_ff == ST_DOUBLE) begin
               unit_x = prod_ff;
               unit_y = prod_ff;
            end else begin
               unit_x = prod_ff;
               unit_y = mcand_ff;
            end
            prod_in = unit_r;
            if (step_done) begin
               mplier_in  = mplier_ff << 1;
               bit_cnt_in = bit_cnt_ff - CNT_W'(1);
            end
            if (mul_done) begin
               acc_in = unit_r;
               if (need_mult) begin
                  phase_in   = PH_MULT;
                  mcand_in   = unit_r;
                  mplier_in  = base_ff;
                  prod_in    = '0;
                  bit_cnt_in = LAST_BIT;
               end else begin
                  exp_in = exp_ff << 1;
                  if (exp_last) begin
                     rsp_strobe_in  = 1'b1;
                     rsp_residue_in = FIELD_W'(unit_r);
                     rsp_zero_in    = 1'b0;
                  end else begin
                     exp_cnt_in = exp_cnt_ff - CNT_W'(1);
                     phase_in   = PH_SQUARE;
                     mcand_in   = unit_r;
                     mplier_in  = unit_r;
                     prod_in    = '0;
                     bit_cnt_in = LAST_BIT;
                  end
               end
            end
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_SQUARE;
         bit_cnt_ff    <= '0;
         exp_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         bit_cnt_ff    <= bit_cnt_in;
         exp_cnt_ff    <= exp_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mod_ff         <= mod_in;
      base_ff        <= base_in;
      exp_ff         <= exp_in;
      acc_ff         <= acc_in;
      prod_ff        <= prod_in;
      mcand_ff       <= mcand_in;
      mplier_ff      <= mplier_in;
      rsp_residue_ff <= rsp_residue_in;
      rsp_zero_ff    <= rsp_zero_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_residue      = rsp_residue_ff;
   assign rsp_zero_modulus = rsp_zero_ff;

   a_zero_mod_fast: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (mod_w == '0)) |=> (rsp_strobe && rsp_zero_modulus))
      else $error("zero modulus word not answered in one cycle");

   a_no_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while sequencer busy");

   a_operands_reduced: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DOUBLE) || (state_ff == ST_ADD)) |->
         ((prod_ff < mod_ff) && (mcand_ff < mod_ff)))
      else $error("product operand not below modulus");

   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_zero_modulus) |-> (acc_ff < mod_ff))
      else $error("residue not below modulus");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("sequencer left idle without a start");

endmodule

FILE: tb/modular_exponentiation_tb.sv
// self-checking testbench of the modular exponentiation block: directed table, then random words
`timescale 1ns / 100ps

module modular_exponentiation_tb;

   import modexp_pkg::*;

   localparam int WIDTH = 32;
   localparam int RANDOM_PER_PHASE = 65;
   localparam int NUM_DIRECTED = 20;

   typedef struct packed {
      logic [FIELD_W-1:0] residue;
      logic               zero_modulus;
   } modexp_result_type;

   typedef struct packed {
      logic [FIELD_W-1:0] base;
      logic [FIELD_W-1:0] exponent;
      logic [FIELD_W-1:0] modulus;
      logic               typed_in;
      logic [FIELD_W-1:0] typed_residue;
      logic               typed_zero;
   } stim_row_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [FIELD_W-1:0] req_base = '0;
   logic [FIELD_W-1:0] req_exponent = '0;
   logic [FIELD_W-1:0] req_modulus = '0;
   logic               rsp_strobe;
   logic [FIELD_W-1:0] rsp_residue;
   logic               rsp_zero_modulus;

   modexp_result_type expected_residues [$];
   stim_row_type      directed_rows [NUM_DIRECTED];
   int                error_count = 0;

   modular_exponentiation #(
      .WIDTH(WIDTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_base(req_base),
      .req_exponent(req_exponent),
      .req_modulus(req_modulus),
      .rsp_strobe(rsp_strobe),
      .rsp_residue(rsp_residue),
      .rsp_zero_modulus(rsp_zero_modulus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // square-and-multiply with native double-width products
   function automatic modexp_result_type predict_power_mod(input logic [FIELD_W-1:0] b,
                                                           input logic [FIELD_W-1:0] e,
                                                           input logic [FIELD_W-1:0] m);
      modexp_result_type r;
      logic [63:0]       acc;
      logic [63:0]       bb;
      logic [63:0]       mm;
      logic [63:0]       wmask;
      wmask = (64'd1 << WIDTH) - 64'd1;
      mm = {32'd0, m} & wmask;
      if (mm == 64'd0) begin
         r.residue = '0;
         r.zero_modulus = 1'b1;
         return r;
      end
      acc = 64'd1 % mm;
      bb = ({32'd0, b} & wmask) % mm;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         acc = (acc * acc) % mm;
         if (e[i])
            acc = (acc * bb) % mm;
      end
      r.residue = acc[FIELD_W-1:0];
      r.zero_modulus = 1'b0;
      return r;
   endfunction

   // hold the word on the ports until an edge sees start high and busy low
   task automatic issue_word(input logic [FIELD_W-1:0] b, input logic [FIELD_W-1:0] e,
                             input logic [FIELD_W-1:0] m, input modexp_result_type want,
                             input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_base <= b;
      req_exponent <= e;
      req_modulus <= m;
      do
         @(posedge clock);
      while (busy);
      expected_residues.push_back(want);
   endtask

   always @(posedge clock) begin
      modexp_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_residues.size() == 0) begin
            $error("unexpected result: residue %h zero_modulus %b", rsp_residue,
                   rsp_zero_modulus);
            error_count++;
         end else begin
            want = expected_residues.pop_front();
            if (rsp_residue !== want.residue) begin
               $error("residue: expected %h, actual %h", want.residue, rsp_residue);
               error_count++;
            end
            if (rsp_zero_modulus !== want.zero_modulus) begin
               $error("zero_modulus: expected %b, actual %b", want.zero_modulus,
                      rsp_zero_modulus);
               error_count++;
            end
         end
      end
   end

   initial begin
      #150_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int                 idle_pct [4];
      modexp_result_type  want;
      logic [FIELD_W-1:0] b;
      logic [FIELD_W-1:0] e;
      logic [FIELD_W-1:0] m;
      int                 pick;

      idle_pct = '{0, 72, 0, 18};

      // zero modulus, zero exponent, modulus one, base not below modulus, extremes
      directed_rows[0]  = {32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, 1'b1};
      directed_rows[1]  = {32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000, 1'b1, 32'h0, 1'b1};
      directed_rows[2]  = {32'h0000_0005, 32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0, 1'b0};
      directed_rows[3]  = {32'h0000_0005, 32'h0000_0000, 32'h0000_0007, 1'b1, 32'h1, 1'b0};
      directed_rows[4]  = {32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 1'b1, 32'h1, 1'b0};
      directed_rows[5]  = {32'h0000_0000, 32'h0000_0000, 32'hffff_ffff, 1'b1, 32'h1, 1'b0};
      directed_rows[6]  = {32'h0000_0000, 32'h0000_0005, 32'hffff_ffff, 1'b1, 32'h0, 1'b0};
      directed_rows[7]  = {32'h0000_0001, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h1, 1'b0};
      directed_rows[8]  = {32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001, 1'b1, 32'h0, 1'b0};
      directed_rows[9]  = {32'h0001_2345, 32'h0000_0678, 32'h0000_0001, 1'b1, 32'h0, 1'b0};
      directed_rows[10] = {32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h0, 1'b0};
      directed_rows[11] = {32'hffff_fffe, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h0, 1'b0};
      directed_rows[12] = {32'h0000_0002, 32'h0000_001f, 32'hffff_ffff, 1'b0, 32'h0, 1'b0};
      directed_rows[13] = {32'h0000_0002, 32'h0000_0020, 32'hffff_ffff, 1'b0, 32'h0, 1'b0};
      directed_rows[14] = {32'h0000_0003, 32'hffff_ffff, 32'hffff_fffb, 1'b0, 32'h0, 1'b0};
      directed_rows[15] = {32'h0000_0064, 32'h0000_0003, 32'h0000_0007, 1'b0, 32'h0, 1'b0};
      directed_rows[16] = {32'hffff_ffff, 32'h0000_0002, 32'hffff_fffe, 1'b0, 32'h0, 1'b0};
      directed_rows[17] = {32'h0000_0007, 32'h0000_0001, 32'hffff_ffff, 1'b0, 32'h0, 1'b0};
      directed_rows[18] = {32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 1'b0, 32'h0, 1'b0};
      directed_rows[19] = {32'h0000_0002, 32'h0000_000a, 32'h0000_1000, 1'b0, 32'h0, 1'b0};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].typed_in) begin
            want.residue = directed_rows[i].typed_residue;
            want.zero_modulus = directed_rows[i].typed_zero;
         end else begin
            want = predict_power_mod(directed_rows[i].base, directed_rows[i].exponent,
                                     directed_rows[i].modulus);
         end
         issue_word(directed_rows[i].base, directed_rows[i].exponent,
                    directed_rows[i].modulus, want, idle_pct[i % 4]);
      end

      for (int phase = 0; phase < 4; phase++) begin
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            pick = $urandom_range(19);
            if (pick == 0)
               m = '0;
            else if (pick == 1)
               m = 32'd1;
            else if (pick <= 4)
               m = $urandom_range(255, 2);
            else if (pick <= 6)
               m = 32'hffff_ffff - $urandom_range(15);
            else if (pick == 7)
               m = 32'h8000_0000 | $urandom;
            else
               m = $urandom;

            pick = $urandom_range(9);
            if (pick == 0)
               b = '0;
            else if (pick == 1)
               b = 32'd1;
            else if (pick == 2)
               b = 32'hffff_ffff;
            else if (pick == 3)
               b = m + $urandom_range(1000);
            else
               b = $urandom;

            pick = $urandom_range(9);
            if (pick == 0)
               e = '0;
            else if (pick == 1)
               e = $urandom_range(3);
            else if (pick == 2)
               e = 32'hffff_ffff;
            else
               e = $urandom;

            issue_word(b, e, m, predict_power_mod(b, e, m), idle_pct[phase]);
         end
      end
      start <= 1'b0;

      while (expected_residues.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: modular_exponentiation.f
hdl/modexp_pkg.sv
hdl/modexp_addmod.sv
hdl/modular_exponentiation.sv
tb/modular_exponentiation_tb.sv
